// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Types, constants and character helpers of the C subset token scanner.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int POS_BITS     = 16;
    localparam int OUT_POS_BITS = 16;
    localparam int KIND_BITS    = 5;
    localparam int NUM_KW       = 8;
    localparam int KW_MAX_LEN   = 6;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    localparam logic [KIND_BITS-1:0] KIND_EOF      = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_PUNCT0   = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_IDENT    = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_KEYWORD0 = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_INT      = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_FLOAT    = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_INVALID  = 5'd19;

    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
        '{"v", "o", "i", "d", 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00},
        '{"s", "h", "o", "r", "t", 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"l", "o", "n", "g", 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00},
        '{"d", "o", "u", "b", "l", "e"},
        '{"r", "e", "t", "u", "r", "n"}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd6, 3'd6};
    localparam logic [7:0] PUNCT [NUM_KW] = '{"(", ")", "{", "}", ";", ":", ",", "="};

    localparam logic [7:0] CHAR_UNDERSCORE = "_";
    localparam logic [7:0] CHAR_DOT        = ".";

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER
    } t_mode;

    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic                    invalid;
        logic [OUT_POS_BITS-1:0] start;
        logic [OUT_POS_BITS-1:0] stop;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == CHAR_UNDERSCORE;
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
        logic [7:0] c;
        c = 8'h00;
        if (i < 3'd6) begin
            c = KW_TEXT[k][i];
        end
        return c;
    endfunction

    function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic logic [OUT_POS_BITS-1:0] out_pos(input logic [POS_BITS-1:0] p);
        logic [OUT_POS_BITS-1:0] r;
        if ((p >> OUT_POS_BITS) != '0) begin
            r = '1;
        end else begin
            r = OUT_POS_BITS'(p);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cst_scan_core.sv =====
// ----------------------------------------------------------------------------
// cst_scan_core
// Scanner state and per-byte token logic; yields up to two tokens per item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cst_scan_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  logic            i_eot,
    output cst_pkg::t_push  o_push
);
    import cst_pkg::*;

    t_mode                 r_mode, n_mode;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [POS_BITS-1:0]   r_begin, n_begin;
    logic [NUM_KW-1:0]     r_kw_match, n_kw_match;
    logic [2:0]            r_wlen, n_wlen;
    logic                  r_has_dot, n_has_dot;

    logic                  w_flush_v;
    logic                  w_cont_word;
    logic                  w_cont_num;
    logic                  w_cont;
    logic                  w_word_start;
    logic                  w_single_v;
    logic                  w_a_v;
    logic                  w_b_v;
    t_result               w_a;
    t_result               w_b;
    logic [KIND_BITS-1:0]  w_flush_kind;
    logic [KIND_BITS-1:0]  w_single_kind;
    logic [NUM_KW-1:0]     w_mask_in;
    logic [NUM_KW-1:0]     w_mask_out;
    logic [2:0]            w_wlen_in;
    logic [2:0]            w_wlen_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_pos      <= '0;
            r_begin    <= '0;
            r_kw_match <= '1;
            r_wlen     <= '0;
            r_has_dot  <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_begin    <= n_begin;
            r_kw_match <= n_kw_match;
            r_wlen     <= n_wlen;
            r_has_dot  <= n_has_dot;
        end
    end

    always_comb begin
        w_flush_v    = (r_mode != MODE_IDLE);
        w_cont_word  = (r_mode == MODE_WORD) && is_word(i_byte);
        w_cont_num   = (r_mode == MODE_NUMBER) && (is_digit(i_byte) || i_byte == CHAR_DOT);
        w_cont       = !i_eot && (w_cont_word || w_cont_num);
        w_word_start = !i_eot && !w_cont && (is_alpha(i_byte) || i_byte == CHAR_UNDERSCORE);
        w_single_v   = !i_eot && !w_cont && !is_space(i_byte) && !is_alpha(i_byte)
                       && i_byte != CHAR_UNDERSCORE && !is_digit(i_byte);

        // keyword match update for the byte joining a word
        w_mask_in = w_word_start ? '1 : r_kw_match;
        w_wlen_in = w_word_start ? 3'd0 : r_wlen;
        w_mask_out = w_mask_in;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!((w_wlen_in < KW_LEN[k]) && (kw_char(k, w_wlen_in) == i_byte))) begin
                w_mask_out[k] = 1'b0;
            end
        end
        w_wlen_out = (w_wlen_in < 3'd7) ? w_wlen_in + 3'd1 : w_wlen_in;

        w_flush_kind = KIND_IDENT;
        if (r_mode == MODE_NUMBER) begin
            w_flush_kind = r_has_dot ? KIND_FLOAT : KIND_INT;
        end else begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (r_kw_match[k] && r_wlen == KW_LEN[k]) begin
                    w_flush_kind = KIND_KEYWORD0 + KIND_BITS'(k);
                end
            end
        end

        w_single_kind = KIND_INVALID;
        for (int k = 0; k < NUM_KW; k++) begin
            if (PUNCT[k] == i_byte) begin
                w_single_kind = KIND_PUNCT0 + KIND_BITS'(k);
            end
        end

        w_a_v         = w_flush_v && (i_eot || !w_cont);
        w_a.kind      = w_flush_kind;
        w_a.invalid   = 1'b0;
        w_a.start     = out_pos(r_begin);
        w_a.stop      = out_pos(r_pos);
        w_a.last      = 1'b0;

        w_b_v = i_eot || w_single_v;
        if (i_eot) begin
            w_b.kind    = KIND_EOF;
            w_b.invalid = 1'b0;
            w_b.start   = out_pos(r_pos);
            w_b.stop    = out_pos(r_pos);
        end else begin
            w_b.kind    = w_single_kind;
            w_b.invalid = (w_single_kind == KIND_INVALID);
            w_b.start   = out_pos(r_pos);
            w_b.stop    = out_pos(pos_inc(r_pos));
        end
        w_b.last = 1'b1;

        o_push.v0 = 1'b0;
        o_push.v1 = 1'b0;
        o_push.r0 = w_a;
        o_push.r1 = w_b;
        if (i_take) begin
            if (w_a_v) begin
                o_push.v0      = 1'b1;
                o_push.v1      = w_b_v;
                o_push.r0.last = !w_b_v;
            end else begin
                o_push.v0 = w_b_v;
                o_push.r0 = w_b;
            end
        end

        n_mode     = r_mode;
        n_pos      = r_pos;
        n_begin    = r_begin;
        n_kw_match = r_kw_match;
        n_wlen     = r_wlen;
        n_has_dot  = r_has_dot;
        if (i_take) begin
            if (i_eot) begin
                n_mode     = MODE_IDLE;
                n_pos      = '0;
                n_begin    = '0;
                n_kw_match = '1;
                n_wlen     = '0;
                n_has_dot  = 1'b0;
            end else begin
                n_pos = pos_inc(r_pos);
                if (w_cont_word) begin
                    n_kw_match = w_mask_out;
                    n_wlen     = w_wlen_out;
                end else if (w_cont_num) begin
                    n_has_dot = r_has_dot || (i_byte == CHAR_DOT);
                end else if (w_word_start) begin
                    n_mode     = MODE_WORD;
                    n_begin    = r_pos;
                    n_kw_match = w_mask_out;
                    n_wlen     = w_wlen_out;
                end else if (is_digit(i_byte)) begin
                    n_mode    = MODE_NUMBER;
                    n_begin   = r_pos;
                    n_has_dot = 1'b0;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
        end
    end

    `ASSERT_CLK(a_pair_order, i_clk, i_rst_n, o_push.v1 |-> o_push.v0, "second token without first")
    `ASSERT_CLK(a_idle_no_push, i_clk, i_rst_n, !i_take |-> !o_push.v0, "token without item")
    `ASSERT_CLK(a_eot_resets, i_clk, i_rst_n, (i_take && i_eot) |=> (r_pos == '0 && r_mode == MODE_IDLE), "end of text did not reset")
    `ASSERT_CLK(a_pos_grows, i_clk, i_rst_n, (i_take && !i_eot) |=> (r_pos >= $past(r_pos)), "position went back")

endmodule

// ===== hw/rtl/cst_out_fifo.sv =====
// ----------------------------------------------------------------------------
// cst_out_fifo
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cst_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cst_pkg::t_push                      i_push,
    input  logic                                i_ready,
    output logic                                o_valid,
    output cst_pkg::t_result                    o_data,
    output logic [cst_pkg::FIFO_CNT_W-1:0]      o_count
);
    import cst_pkg::*;

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr, n_wr;
    logic [FIFO_PTR_W-1:0]   r_rd, n_rd;
    logic [FIFO_CNT_W-1:0]   r_count, n_count;
    logic [FIFO_PTR_W-1:0]   w_wr1;
    logic                    w_pop;
    logic [FIFO_CNT_W-1:0]   w_push_n;

    assign w_wr1    = r_wr + 1'b1;
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd];
    assign o_count  = r_count;
    assign w_pop    = o_valid && i_ready;
    assign w_push_n = FIFO_CNT_W'(i_push.v0) + FIFO_CNT_W'(i_push.v1);

    always_comb begin
        n_wr    = r_wr + FIFO_PTR_W'(w_push_n);
        n_rd    = r_rd + FIFO_PTR_W'(w_pop);
        n_count = r_count + w_push_n - FIFO_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[w_wr1] <= i_push.r1;
        end
    end

    `ASSERT_CLK(a_room, i_clk, i_rst_n, i_push.v0 |-> (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)), "push without room")
    `ASSERT_NEVER(a_bound, i_clk, i_rst_n, r_count > FIFO_CNT_W'(FIFO_DEPTH), "count past depth")
    `ASSERT_CLK(a_pop_only, i_clk, i_rst_n, (w_pop && !i_push.v0) |=> (r_count == $past(r_count) - 1'b1), "pop miscounted")

endmodule

// ===== hw/rtl/c_subset_token_scanner.sv =====
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Streaming lexer for a small C subset: bytes in, tokens with positions out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle. Each byte is registered, classified
// against the running scanner state, and the zero, one or two tokens it
// completes are written to a four-entry result queue that drives the master
// port, so the first token of an item reaches the master port once the item
// has passed the input register and been written to the queue. The queue
// delivers one token per cycle when the master accepts; the slave port stalls
// only while the queue holds more than two tokens, so input runs at one byte
// per cycle unless the master stalls or many bytes in a row end two tokens.
module c_subset_token_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tuser,   // [0] end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_end
    output logic [5:0]  m_axis_tuser,   // [4:0] token_kind, [5] is_invalid
    output logic        m_axis_tlast
);
    import cst_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_eot;
    logic                   w_fire;
    logic                   w_room;
    logic [FIFO_CNT_W-1:0]  w_count;
    t_push                  w_push;
    t_result                w_out;

    assign w_room        = (w_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign w_fire        = r_in_valid && w_room;
    assign s_axis_tready = !r_in_valid || w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eot  <= s_axis_tuser;
        end
    end

    cst_scan_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_fire),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .o_push  (w_push)
    );

    cst_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .o_count (w_count)
    );

    assign m_axis_tdata = {w_out.stop, w_out.start};
    assign m_axis_tuser = {w_out.invalid, w_out.kind};
    assign m_axis_tlast = w_out.last;

endmodule
